>>> src/cde_pkg.sv
// Shared types and constants of the cosine distance engine.
`default_nettype none
package cde_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned FRAC_EXT = 31;   // 14 fraction bits of the result plus one rounding bit
  localparam logic [15:0] COS_ONE = 16'd16384;
  localparam logic [15:0] NOV_MAX = 16'd32768;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_SQRT,
    ST_MUL,
    ST_DIVLD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic load_sqrt;
    logic step_sqrt;
    logic mul;
    logic load_div;
    logic step_div;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sq_last;
    logic div_last;
    logic zero_norm;
  } sts_t;

endpackage
`default_nettype wire

>>> src/cde_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle while step_i is high.
`default_nettype none
module cde_isqrt #(
  parameter int unsigned RT_W = 29
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic              step_i,
  input  wire logic [2*RT_W-1:0] rad_i,
  output logic      [RT_W-1:0]   root_o
);
  localparam int unsigned RAD_W = 2 * RT_W;
  localparam int unsigned REM_W = RT_W + 2;
  localparam int unsigned TRY_W = RT_W + 4;

  logic [RAD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [RT_W-1:0]  root_q, root_d;
  logic [TRY_W-1:0] shifted, trial;
  logic             ge;

  always_comb begin
    shifted = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    ge      = shifted >= trial;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    if (load_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (step_i) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      rem_d  = ge ? REM_W'(shifted - trial) : shifted[REM_W-1:0];
      root_d = {root_q[RT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
endmodule
`default_nettype wire

>>> src/cde_datapath.sv
// Datapath: accumulators, square roots, norm product, divider and result register.
`default_nettype none
module cde_datapath #(
  parameter int unsigned MAX_LEN = cde_pkg::MAX_LEN_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cde_pkg::cmd_t cmd_i,
  output cde_pkg::sts_t      sts_o,
  input  wire logic [31:0]   elems_i,
  output logic      [15:0]   novelty_o,
  output logic               zero_norm_o,
  output logic               overflow_o
);
  import cde_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ACC_W  = 33 + $clog2(MAX_LEN);
  localparam int unsigned SQ_W   = 32 + $clog2(MAX_LEN);
  localparam int unsigned RT_W   = (SQ_W + 17) / 2;
  localparam int unsigned RAD_W  = 2 * RT_W;
  localparam int unsigned P_W    = 2 * RT_W;
  localparam int unsigned NUM_W  = ACC_W + FRAC_EXT;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic signed [ELEM_W-1:0] e, c;
  logic signed [31:0]       p_ec, p_ee, p_cc;
  logic signed [ACC_W-1:0]  dot_q;
  logic [SQ_W-1:0]          esq_q, csq_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     ovf_q, zero_q, neg_q;
  logic [STEP_W-1:0]        step_q;
  logic [RT_W-1:0]          root_e, root_c;
  logic [P_W-1:0]           p_q;
  logic [NUM_W-1:0]         num_q;
  logic [P_W-1:0]           rem_q;
  logic [ACC_W-1:0]         mag;
  logic [P_W:0]             trial;
  logic                     ge;
  logic [NUM_W-1:0]         q_rnd;
  logic [15:0]              q_sat;
  logic [16:0]              neg_sum;
  logic [15:0]              nov;
  logic [15:0]              nov_q;
  logic                     zero_out_q, ovf_out_q;

  assign e    = elems_i[15:0];
  assign c    = elems_i[31:16];
  assign p_ec = e * c;
  assign p_ee = e * e;
  assign p_cc = c * c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      esq_q <= '0;
      csq_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      dot_q <= '0;
      esq_q <= '0;
      csq_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (cnt_q < CNT_W'(MAX_LEN)) begin
        dot_q <= dot_q + {{(ACC_W-32){p_ec[31]}}, p_ec};
        esq_q <= esq_q + {{(SQ_W-32){1'b0}}, p_ee};
        csq_q <= csq_q + {{(SQ_W-32){1'b0}}, p_cc};
        cnt_q <= cnt_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  cde_isqrt #(.RT_W(RT_W)) u_sqrt_emb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cmd_i.load_sqrt),
    .step_i (cmd_i.step_sqrt),
    .rad_i  (RAD_W'({esq_q, 16'h0000})),
    .root_o (root_e)
  );

  cde_isqrt #(.RT_W(RT_W)) u_sqrt_cen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cmd_i.load_sqrt),
    .step_i (cmd_i.step_sqrt),
    .rad_i  (RAD_W'({csq_q, 16'h0000})),
    .root_o (root_c)
  );

  assign mag   = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, p_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      zero_q <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      if (cmd_i.load_sqrt || cmd_i.load_div) begin
        step_q <= '0;
      end else if (cmd_i.step_sqrt || cmd_i.step_div) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.load_sqrt) begin
        zero_q <= (esq_q == '0) || (csq_q == '0);
      end
      if (cmd_i.load_div) begin
        neg_q <= dot_q[ACC_W-1];
      end
    end
  end

  // Norm product, then long division of the dot magnitude, scaled by 2^31, by it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_q <= root_e * root_c;
    end
    if (cmd_i.load_div) begin
      num_q <= {mag, {FRAC_EXT{1'b0}}};
      rem_q <= '0;
    end else if (cmd_i.step_div) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? P_W'(trial - {1'b0, p_q}) : trial[P_W-1:0];
    end
  end

  always_comb begin
    q_rnd   = {1'b0, num_q[NUM_W-1:1]} + NUM_W'(num_q[0]);
    q_sat   = (q_rnd > NUM_W'(NOV_MAX)) ? NOV_MAX : q_rnd[15:0];
    neg_sum = {1'b0, COS_ONE} + {1'b0, q_sat};
    if (zero_q) begin
      nov = '0;
    end else if (neg_q) begin
      nov = (neg_sum > {1'b0, NOV_MAX}) ? NOV_MAX : neg_sum[15:0];
    end else begin
      nov = (q_sat >= COS_ONE) ? '0 : COS_ONE - q_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      nov_q      <= nov;
      zero_out_q <= zero_q;
      ovf_out_q  <= ovf_q;
    end
  end

  assign sts_o.sq_last   = step_q == STEP_W'(RT_W - 1);
  assign sts_o.div_last  = step_q == STEP_W'(NUM_W - 1);
  assign sts_o.zero_norm = zero_q;
  assign novelty_o       = nov_q;
  assign zero_norm_o     = zero_out_q;
  assign overflow_o      = ovf_out_q;
endmodule
`default_nettype wire

>>> src/cde_ctrl.sv
// Controller: sequences accumulation, roots, product, division and result hand-off.
`default_nettype none
module cde_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  input  wire logic          out_ready_i,
  input  wire cde_pkg::sts_t sts_i,
  output cde_pkg::cmd_t      cmd_o,
  output logic               in_ready_o,
  output logic               out_valid_o
);
  import cde_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC:   if (in_valid_i && in_last_i) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_SQRT;
      ST_SQRT: begin
        if (sts_i.zero_norm) begin
          state_d = ST_FIN;
        end else if (sts_i.sq_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_DIVLD;
      ST_DIVLD: state_d = ST_DIV;
      ST_DIV:   if (sts_i.div_last) state_d = ST_FIN;
      ST_FIN:   if (can_load) state_d = ST_ACC;
      default:  state_d = ST_ACC;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
      end
      ST_LOAD:  cmd_o.load_sqrt = 1'b1;
      ST_SQRT:  cmd_o.step_sqrt = !sts_i.zero_norm;
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_DIVLD: cmd_o.load_div = 1'b1;
      ST_DIV:   cmd_o.step_div = 1'b1;
      ST_FIN:   cmd_o.load_out = can_load;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

>>> src/cosine_distance_engine.sv
// Top level of the streaming cosine distance engine.
// Element pairs are accepted one per cycle while a vector streams in; each
// request is accumulated with three multiply-adds. After the request marked
// last the input stalls while the two-bit-per-cycle square root units
// (RT_W = root width, 29 at the default length) and the one-bit-per-cycle
// divider (NUM_W = 74 at the default length) run, then the result is held
// in an output register until taken. A zero norm skips the root and divide
// phases. Pairs beyond MAX_LEN are dropped and flagged.
`default_nettype none
module cosine_distance_engine #(
  parameter int unsigned MAX_LEN = cde_pkg::MAX_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // emb_elem [15:0], cen_elem [31:16]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // novelty [15:0]
  output logic      [1:0]  m_axis_tuser    // zero_norm [0], length_overflow [1]
);
  import cde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  cde_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .elems_i     (s_axis_tdata),
    .novelty_o   (m_axis_tdata),
    .zero_norm_o (m_axis_tuser[0]),
    .overflow_o  (m_axis_tuser[1])
  );

  // A last request starts the computation, so input stalls in the next cycle.
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input accepted right after last request");

  a_zero_norm_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("zero norm result is not zero");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= NOV_MAX))
    else $error("novelty beyond 2.0");
endmodule
`default_nettype wire

>>> sim/cosine_distance_engine_tb.sv
// Self-checking testbench for the streaming cosine distance engine.
`default_nettype none
module cosine_distance_engine_tb;

  localparam int unsigned VEC_MAX = cde_pkg::MAX_LEN_DEF;

  typedef struct packed {
    logic [15:0] novelty;
    logic        zero_norm;
    logic        length_overflow;
  } distance_t;

  // Running sums of one vector pair and the queue of distances they produce.
  class distance_board;
    longint    dot_sum;
    longint    emb_sq_sum;
    longint    cen_sq_sum;
    int        pair_count;
    bit        dropped;
    distance_t pending[$];
    int        errors;

    function new();
      clear_sums();
      errors = 0;
    endfunction

    function void clear_sums();
      dot_sum = 0;
      emb_sq_sum = 0;
      cen_sq_sum = 0;
      pair_count = 0;
      dropped = 0;
    endfunction

    function longint unsigned int_root(longint unsigned x);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= root + b) begin
          x -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function void note_pair(logic signed [15:0] emb, logic signed [15:0] cen, bit is_last);
      distance_t d;
      longint unsigned se, sc, prod, mag, quo, rem;
      longint diff;
      if (pair_count < VEC_MAX) begin
        dot_sum += longint'(emb) * longint'(cen);
        emb_sq_sum += longint'(emb) * longint'(emb);
        cen_sq_sum += longint'(cen) * longint'(cen);
        pair_count++;
      end else begin
        dropped = 1;
      end
      if (!is_last) return;
      d = '0;
      d.length_overflow = dropped;
      if (emb_sq_sum == 0 || cen_sq_sum == 0) begin
        d.zero_norm = 1;
      end else begin
        se = int_root(longint'(emb_sq_sum) << 16);
        sc = int_root(longint'(cen_sq_sum) << 16);
        prod = se * sc;
        mag = dot_sum < 0 ? -dot_sum : dot_sum;
        quo = mag / prod;
        rem = mag % prod;
        // 14 fraction bits and one rounding bit by long division.
        for (int i = 0; i < 31; i++) begin
          rem <<= 1;
          quo <<= 1;
          if (rem >= prod) begin
            rem -= prod;
            quo |= 1;
          end
        end
        quo = (quo + 1) >> 1;
        if (quo > 32768) quo = 32768;
        diff = dot_sum < 0 ? 16384 + longint'(quo) : 16384 - longint'(quo);
        if (diff < 0) diff = 0;
        if (diff > 32768) diff = 32768;
        d.novelty = diff[15:0];
      end
      pending.push_back(d);
      clear_sums();
    endfunction

    function void check_distance(logic [15:0] novelty, logic [1:0] flags);
      distance_t want;
      if (pending.size() == 0) begin
        $error("distance output with none pending: novelty %0d flags %b", novelty, flags);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (novelty !== want.novelty) begin
        $error("novelty: expected %0d, got %0d", want.novelty, novelty);
        errors++;
      end
      if (flags[0] !== want.zero_norm) begin
        $error("zero_norm: expected %0d, got %0d", want.zero_norm, flags[0]);
        errors++;
      end
      if (flags[1] !== want.length_overflow) begin
        $error("length_overflow: expected %0d, got %0d", want.length_overflow, flags[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  distance_board board = new();
  int  burst_left = 0;
  bit  long_hold = 0;

  cosine_distance_engine u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Offers one request and waits until it is taken; gaps fall between bursts.
  task automatic send_pair(logic signed [15:0] emb, logic signed [15:0] cen, bit is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {cen, emb};
    s_axis_tlast <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(emb, cen, is_last);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_elem(int mode);
    case (mode)
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_vector(int len, int mode);
    logic signed [15:0] emb, cen;
    for (int i = 0; i < len; i++) begin
      emb = pick_elem(mode == 5 ? ($urandom_range(0, 9) < 2 ? $urandom_range(0, 2) : 4) : mode);
      cen = pick_elem(mode == 5 ? ($urandom_range(0, 9) < 2 ? $urandom_range(0, 2) : 4) : mode);
      if (mode == 6) cen = emb;
      if (mode == 7) cen = -emb;
      send_pair(emb, cen, i == len - 1);
    end
  endtask

  // Receiver: own stall pattern plus one long hold-off while the sender keeps going.
  always @(negedge clk_i) begin
    if (long_hold) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(0, 15) < 4) ? 0 : 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_distance(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    repeat (200) @(posedge clk_i);
    long_hold = 1;
    repeat (300) @(posedge clk_i);
    long_hold = 0;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Directed: extremes, zero norms, parallel and opposite vectors, single pair.
    send_pair(16'h7FFF, 16'h7FFF, 1);
    send_pair(16'h8000, 16'h8000, 1);
    send_pair(16'h8000, 16'h7FFF, 1);
    send_pair(16'h0000, 16'h1234, 1);
    send_pair(16'h1234, 16'h0000, 1);
    send_pair(16'h0000, 16'h0000, 1);
    send_pair(16'h0001, 16'hFFFF, 1);
    send_pair(16'h1000, 16'h0000, 0);
    send_pair(16'h0000, 16'h1000, 1);
    send_vector(4, 6);
    send_vector(4, 7);
    send_vector(3, 3);
    // Overflow at full-scale elements: the dropped pair is the last one.
    send_vector(VEC_MAX + 1, 1);
    send_vector(2, 4);
    for (int n = 0; n < 150; n += 0) begin
      int len, mode;
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      mode = $urandom_range(3, 7);
      send_vector(len, mode);
      n += len;
    end
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
